### rtl/pid_differential_thrust_top_macros.svh
// assertion macros shared by the pid differential thrust rtl
// expects clk and rst_n in the scope of each use
`ifndef PID_DIFFERENTIAL_THRUST_TOP_MACROS_SVH
`define PID_DIFFERENTIAL_THRUST_TOP_MACROS_SVH

// same-cycle implication
`define PDT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdt: same-cycle check failed");

// next-cycle implication
`define PDT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdt: next-cycle check failed");

`endif

### rtl/pdt_pkg.sv
// shared widths, register codes, word types and the thrust clamp
// for the pid differential thrust block; no dependencies
package pdt_pkg;

  localparam int GAIN_FRAC_BITS = 12;
  localparam int SUM_W          = 24;
  localparam int GAIN_W         = 16;
  localparam int ANGLE_W        = 9;
  localparam int ERR_W          = ANGLE_W + 1;
  localparam int DIFF_W         = ERR_W + 1;
  localparam int THRUST_W       = 8;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 2 * THRUST_W;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = GAIN_W;

  localparam int PP_W  = GAIN_W + 1 + ERR_W;
  localparam int PI_W  = GAIN_W + 1 + SUM_W;
  localparam int PD_W  = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W = PI_W + 2;
  localparam int U_W   = ACC_W - GAIN_FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_ANGLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_THRUST  = 3'd4;

  localparam logic [GAIN_W-1:0]          RST_GAIN_P = 16'd492;
  localparam logic [GAIN_W-1:0]          RST_GAIN_I = 16'd410;
  localparam logic [GAIN_W-1:0]          RST_GAIN_D = 16'd1024;
  localparam logic signed [ANGLE_W-1:0]  RST_TARGET = '0;
  localparam logic [THRUST_W-1:0]        RST_BASE   = '0;

  localparam logic [THRUST_W-1:0] THRUST_MAX = '1;

  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DIFF_W-1:0] diff;
  } err_word_t;

  typedef struct packed {
    logic signed [PP_W-1:0] pp;
    logic signed [PI_W-1:0] pi;
    logic signed [PD_W-1:0] pd;
  } prod_word_t;

  function automatic logic [THRUST_W-1:0] sat_thrust(input logic signed [U_W:0] t);
    logic [THRUST_W-1:0] r;
    if (t < 0) begin
      r = '0;
    end else if (t > $signed({{(U_W + 1 - THRUST_W){1'b0}}, THRUST_MAX})) begin
      r = THRUST_MAX;
    end else begin
      r = t[THRUST_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/pdt_integrator.sv
// input stage: error, saturating integral and difference, held in the first word register
// depends on pdt_pkg and the assertion macro header
`include "pid_differential_thrust_top_macros.svh"

module pdt_integrator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic signed [pdt_pkg::ANGLE_W-1:0]    set_angle,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pdt_pkg::ANGLE_W-1:0]    meas_angle,
  output logic                                  s1_valid,
  input  logic                                  s1_ready,
  output pdt_pkg::err_word_t                    s1_data
);

  logic                                 accept;
  logic                                 v_r;
  pdt_pkg::err_word_t                   data_r;
  pdt_pkg::err_word_t                   data_nxt;
  logic signed [pdt_pkg::SUM_W-1:0]     sum_r;
  logic signed [pdt_pkg::ERR_W-1:0]     last_err_r;
  logic signed [pdt_pkg::SUM_W:0]       sum_wide;

  assign in_ready = !v_r || s1_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    data_nxt.err = pdt_pkg::ERR_W'(set_angle) - pdt_pkg::ERR_W'(meas_angle);
    sum_wide     = (pdt_pkg::SUM_W + 1)'(sum_r) + (pdt_pkg::SUM_W + 1)'(data_nxt.err);
    // saturate at the bounds of the integral register
    if (sum_wide[pdt_pkg::SUM_W] != sum_wide[pdt_pkg::SUM_W-1]) begin
      data_nxt.sum = {sum_wide[pdt_pkg::SUM_W],
                      {(pdt_pkg::SUM_W - 1){~sum_wide[pdt_pkg::SUM_W]}}};
    end else begin
      data_nxt.sum = sum_wide[pdt_pkg::SUM_W-1:0];
    end
    data_nxt.diff = pdt_pkg::DIFF_W'(data_nxt.err) - pdt_pkg::DIFF_W'(last_err_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= 1'b0;
      sum_r      <= '0;
      last_err_r <= '0;
    end else begin
      if (in_ready) begin
        v_r <= in_valid;
      end
      if (accept) begin
        sum_r      <= data_nxt.sum;
        last_err_r <= data_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= data_nxt;
    end
  end

  assign s1_valid = v_r;
  assign s1_data  = data_r;

  `PDT_ASSERT_NXT(a_last_err_follows, accept, last_err_r == data_r.err && v_r)
  `PDT_ASSERT_NXT(a_sum_follows, accept, sum_r == data_r.sum)

endmodule

### rtl/pdt_effort.sv
// control effort: three gain products, then their sum, each behind a word register
// depends on pdt_pkg
module pdt_effort (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [pdt_pkg::GAIN_W-1:0]            gain_p,
  input  logic [pdt_pkg::GAIN_W-1:0]            gain_i,
  input  logic [pdt_pkg::GAIN_W-1:0]            gain_d,
  input  logic                                  s1_valid,
  output logic                                  s1_ready,
  input  pdt_pkg::err_word_t                    s1_data,
  output logic                                  acc_valid,
  input  logic                                  acc_ready,
  output logic signed [pdt_pkg::ACC_W-1:0]      acc_data
);

  logic                                 v2_r;
  logic                                 v3_r;
  logic                                 ready2;
  logic                                 ready3;
  pdt_pkg::prod_word_t                  prod_r;
  pdt_pkg::prod_word_t                  prod_nxt;
  logic signed [pdt_pkg::ACC_W-1:0]     acc_r;
  logic signed [pdt_pkg::ACC_W-1:0]     acc_nxt;

  assign ready3   = !v3_r || acc_ready;
  assign ready2   = !v2_r || ready3;
  assign s1_ready = ready2;

  always_comb begin
    prod_nxt.pp = $signed({1'b0, gain_p}) * s1_data.err;
    prod_nxt.pi = $signed({1'b0, gain_i}) * s1_data.sum;
    prod_nxt.pd = $signed({1'b0, gain_d}) * s1_data.diff;
    acc_nxt     = pdt_pkg::ACC_W'(prod_r.pp) + pdt_pkg::ACC_W'(prod_r.pi)
                + pdt_pkg::ACC_W'(prod_r.pd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ready2) begin
        v2_r <= s1_valid;
      end
      if (ready3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      prod_r <= prod_nxt;
    end
    if (ready3 && v2_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc_valid = v3_r;
  assign acc_data  = acc_r;

endmodule

### rtl/pdt_mix.sv
// rounding of the effort and the two clamped motor thrusts, held in the output register
// depends on pdt_pkg and the assertion macro header
`include "pid_differential_thrust_top_macros.svh"

module pdt_mix (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [pdt_pkg::THRUST_W-1:0]          base_thrust,
  input  logic                                  acc_valid,
  output logic                                  acc_ready,
  input  logic signed [pdt_pkg::ACC_W-1:0]      acc_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pdt_pkg::THRUST_W-1:0]          thrust_motor_one,
  output logic [pdt_pkg::THRUST_W-1:0]          thrust_motor_two
);

  localparam logic signed [pdt_pkg::ACC_W-1:0] HALF =
    pdt_pkg::ACC_W'(1) <<< (pdt_pkg::GAIN_FRAC_BITS - 1);

  logic                                 out_valid_r;
  logic [pdt_pkg::THRUST_W-1:0]         m1_r;
  logic [pdt_pkg::THRUST_W-1:0]         m2_r;
  logic signed [pdt_pkg::ACC_W-1:0]     rnd;
  logic signed [pdt_pkg::U_W-1:0]       u;
  logic signed [pdt_pkg::U_W:0]         base_x;
  logic signed [pdt_pkg::U_W:0]         t1;
  logic signed [pdt_pkg::U_W:0]         t2;

  assign acc_ready = !out_valid_r || out_ready;

  // halves go away from zero: negative efforts round with one less than half
  always_comb begin
    rnd    = acc_data + (acc_data[pdt_pkg::ACC_W-1] ? (HALF - pdt_pkg::ACC_W'(1)) : HALF);
    u      = rnd[pdt_pkg::ACC_W-1:pdt_pkg::GAIN_FRAC_BITS];
    base_x = $signed({{(pdt_pkg::U_W + 1 - pdt_pkg::THRUST_W){1'b0}}, base_thrust});
    t1     = base_x + (pdt_pkg::U_W + 1)'(u);
    t2     = base_x - (pdt_pkg::U_W + 1)'(u);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc_ready) begin
      out_valid_r <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_ready && acc_valid) begin
      m1_r <= pdt_pkg::sat_thrust(t1);
      m2_r <= pdt_pkg::sat_thrust(t2);
    end
  end

  assign out_valid        = out_valid_r;
  assign thrust_motor_one = m1_r;
  assign thrust_motor_two = m2_r;

  `PDT_ASSERT_NXT(a_out_loads, acc_valid && acc_ready, out_valid_r)
  `PDT_ASSERT_IMP(a_thrusts_opposite, out_valid_r, (m1_r >= base_thrust && m2_r <= base_thrust) || (m1_r <= base_thrust && m2_r >= base_thrust))

endmodule

### rtl/pid_differential_thrust_top.sv
// pid roll controller with differential two-motor thrust output
// one roll angle word in, one pair of thrusts out; depends on pdt_pkg and the stage modules
//
// Takes one roll angle word per clock unless the output stalls, and returns one thrust word per
// accepted angle, in order. Each angle word passes through a four-register pipeline: error and
// saturating integral, the three gain products, their sum, then rounding and clamping into the
// output register.
// The integral and previous error update as each angle is accepted, so words may follow back to
// back at one per cycle unless the output stalls; empty pipeline stages fill while a result waits.
// Gains, target and base thrust should be written only while no word is in flight.
module pid_differential_thrust_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pdt_pkg::IN_TDATA_W-1:0]        in_tdata,   // [8:0] meas_angle, rest zero
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pdt_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [7:0] motor one, [15:8] motor two
  input  logic                                  cfg_we,
  input  logic [pdt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pdt_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  logic [pdt_pkg::GAIN_W-1:0]           gain_p_r;
  logic [pdt_pkg::GAIN_W-1:0]           gain_i_r;
  logic [pdt_pkg::GAIN_W-1:0]           gain_d_r;
  logic signed [pdt_pkg::ANGLE_W-1:0]   target_r;
  logic [pdt_pkg::THRUST_W-1:0]         base_r;

  logic                                 s1_valid;
  logic                                 s1_ready;
  pdt_pkg::err_word_t                   s1_data;
  logic                                 acc_valid;
  logic                                 acc_ready;
  logic signed [pdt_pkg::ACC_W-1:0]     acc_data;
  logic [pdt_pkg::THRUST_W-1:0]         m1;
  logic [pdt_pkg::THRUST_W-1:0]         m2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= pdt_pkg::RST_GAIN_P;
      gain_i_r <= pdt_pkg::RST_GAIN_I;
      gain_d_r <= pdt_pkg::RST_GAIN_D;
      target_r <= pdt_pkg::RST_TARGET;
      base_r   <= pdt_pkg::RST_BASE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pdt_pkg::REG_GAIN_P:       gain_p_r <= cfg_wdata[pdt_pkg::GAIN_W-1:0];
        pdt_pkg::REG_GAIN_I:       gain_i_r <= cfg_wdata[pdt_pkg::GAIN_W-1:0];
        pdt_pkg::REG_GAIN_D:       gain_d_r <= cfg_wdata[pdt_pkg::GAIN_W-1:0];
        pdt_pkg::REG_SET_ANGLE:    target_r <= $signed(cfg_wdata[pdt_pkg::ANGLE_W-1:0]);
        pdt_pkg::REG_BASE_THRUST:  base_r   <= cfg_wdata[pdt_pkg::THRUST_W-1:0];
        default: ;
      endcase
    end
  end

  pdt_integrator u_integrator (
    .clk          (clk),
    .rst_n        (rst_n),
    .set_angle    (target_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .meas_angle   ($signed(in_tdata[pdt_pkg::ANGLE_W-1:0])),
    .s1_valid     (s1_valid),
    .s1_ready     (s1_ready),
    .s1_data      (s1_data)
  );

  pdt_effort u_effort (
    .clk       (clk),
    .rst_n     (rst_n),
    .gain_p    (gain_p_r),
    .gain_i    (gain_i_r),
    .gain_d    (gain_d_r),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_data   (s1_data),
    .acc_valid (acc_valid),
    .acc_ready (acc_ready),
    .acc_data  (acc_data)
  );

  pdt_mix u_mix (
    .clk              (clk),
    .rst_n            (rst_n),
    .base_thrust      (base_r),
    .acc_valid        (acc_valid),
    .acc_ready        (acc_ready),
    .acc_data         (acc_data),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .thrust_motor_one (m1),
    .thrust_motor_two (m2)
  );

  assign out_tdata = {m2, m1};

endmodule

### test/pid_differential_thrust_checker.sv
`timescale 1ns / 100ps
// thrust checker for the pid differential thrust block: follows register writes, predicts
// each thrust word from the accepted roll angle words and compares in order; needs pdt_pkg
module pid_differential_thrust_checker
  import pdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [8:0] meas_angle, rest zero
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] thrust_motor_one, [15:8] thrust_motor_two
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned            fail_count,
  output int unsigned            words_in_flight
);

  typedef struct packed {
    logic [THRUST_W-1:0] motor_two;
    logic [THRUST_W-1:0] motor_one;
  } thrust_pair_t;

  logic [GAIN_W-1:0]         kp;
  logic [GAIN_W-1:0]         ki;
  logic [GAIN_W-1:0]         kd;
  logic signed [ANGLE_W-1:0] setpoint;
  logic [THRUST_W-1:0]       base_level;
  logic signed [SUM_W-1:0]   integral;
  logic signed [ERR_W-1:0]   prev_err;
  thrust_pair_t              expected_thrusts[$];

  function automatic logic [THRUST_W-1:0] clamp_thrust(input longint t);
    if (t < 0) return '0;
    if (t > longint'(THRUST_MAX)) return THRUST_MAX;
    return t[THRUST_W-1:0];
  endfunction

  // advances integral and previous error, returns the pair of thrusts for one angle
  function automatic thrust_pair_t predict_thrusts(input logic signed [ANGLE_W-1:0] roll);
    longint sum_hi;
    longint sum_lo;
    longint err;
    longint sum_next;
    longint slope;
    longint effort;
    longint mag;
    longint u;
    longint gp;
    longint gi;
    longint gd;
    longint base;
    thrust_pair_t r;
    sum_hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    sum_lo = -sum_hi - 1;
    gp = kp;
    gi = ki;
    gd = kd;
    base = base_level;
    err = setpoint - roll;
    sum_next = integral + err;
    if (sum_next > sum_hi) sum_next = sum_hi;
    if (sum_next < sum_lo) sum_next = sum_lo;
    integral = SUM_W'(sum_next);
    slope = err - prev_err;
    prev_err = ERR_W'(err);
    effort = gp * err + gi * sum_next + gd * slope;
    // round half away from zero
    mag = (effort < 0) ? -effort : effort;
    mag = (mag + (longint'(1) <<< (GAIN_FRAC_BITS - 1))) >>> GAIN_FRAC_BITS;
    u = (effort < 0) ? -mag : mag;
    r.motor_one = clamp_thrust(base + u);
    r.motor_two = clamp_thrust(base - u);
    return r;
  endfunction

  always @(posedge clk) begin
    thrust_pair_t seen;
    thrust_pair_t want;
    if (!rst_n) begin
      kp = RST_GAIN_P;
      ki = RST_GAIN_I;
      kd = RST_GAIN_D;
      setpoint = RST_TARGET;
      base_level = RST_BASE;
      integral = '0;
      prev_err = '0;
      fail_count = 0;
      expected_thrusts.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (expected_thrusts.size() == 0) begin
          $error("thrust word %h with no roll angle word waiting", out_tdata);
          fail_count++;
        end else begin
          want = expected_thrusts.pop_front();
          if (seen.motor_one !== want.motor_one) begin
            $error("thrust_motor_one: expected %0d, got %0d", want.motor_one, seen.motor_one);
            fail_count++;
          end
          if (seen.motor_two !== want.motor_two) begin
            $error("thrust_motor_two: expected %0d, got %0d", want.motor_two, seen.motor_two);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_thrusts.push_back(predict_thrusts(in_tdata[ANGLE_W-1:0]));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_GAIN_P: kp = cfg_wdata;
          REG_GAIN_I: ki = cfg_wdata;
          REG_GAIN_D: kd = cfg_wdata;
          REG_SET_ANGLE: setpoint = cfg_wdata[ANGLE_W-1:0];
          REG_BASE_THRUST: base_level = cfg_wdata[THRUST_W-1:0];
          default: ;
        endcase
      end
    end
    words_in_flight = expected_thrusts.size();
  end

endmodule

### test/pid_differential_thrust_top_test.sv
`timescale 1ns / 100ps
// stimulus and verdict for the pid differential thrust block: roll angle words and register
// writes under varied stalls; needs pdt_pkg, the block and pid_differential_thrust_checker
module pid_differential_thrust_top_test;
  import pdt_pkg::*;

  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_FIRST   = 3'd5;
  localparam logic [CFG_IDX_W-1:0]     REG_SPARE_LAST    = 3'd7;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX        = 9'h0FF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN        = 9'h100;
  localparam int                        WORDS_PER_SETTING = 104;
  localparam int                        SETTINGS_PER_MODE = 5;
  localparam int                        SAT_RUN           = 20;
  localparam int                        HOLD_CYCLES       = 400;
  localparam int                        DRAIN_PAD         = 8;
  localparam int                        STALL_LIMIT       = 4000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [8:0] meas_angle, rest zero
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [7:0] thrust_motor_one, [15:8] thrust_motor_two
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int unsigned               fail_count;
  int unsigned               words_in_flight;
  int                        in_idle_pct = 0;
  int                        out_idle_pct = 0;
  logic                      hold_request = 1'b0;
  logic                      hold_done = 1'b0;
  int                        hold_left = 0;
  int                        quiet_cycles = 0;
  logic signed [ANGLE_W-1:0] aim = '0;
  logic signed [ANGLE_W-1:0] opening_angles[10] = '{0, 1, -1, 180, -180, 255, -256, 255,
                                                    -256, 0};

  pid_differential_thrust_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pid_differential_thrust_checker thrust_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .words_in_flight(words_in_flight)
  );

  always #5 clk = ~clk;

  // receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (int'($urandom_range(99)) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL pid_differential_thrust_top");
      $finish;
    end
  end

  task automatic send_angle(input logic signed [ANGLE_W-1:0] roll);
    while (int'($urandom_range(99)) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W - ANGLE_W){1'b0}}, roll};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering and let every thrust word come out
  task automatic settle();
    in_tvalid <= 1'b0;
    while (words_in_flight != 0) @(negedge clk);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(1200));
    endcase
  endfunction

  task automatic load_random_settings();
    logic [CFG_DATA_W-1:0] word;
    write_reg(REG_GAIN_P, pick_gain());
    write_reg(REG_GAIN_I, pick_gain());
    write_reg(REG_GAIN_D, pick_gain());
    if ($urandom_range(4) == 0) begin
      word = CFG_DATA_W'($urandom);
    end else begin
      word = CFG_DATA_W'(int'($urandom_range(360)) - 180);
    end
    aim = word[ANGLE_W-1:0];
    write_reg(REG_SET_ANGLE, word);
    case ($urandom_range(3))
      0: word = '0;
      1: word = CFG_DATA_W'(THRUST_MAX);
      default: word = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_BASE_THRUST, word);
    if ($urandom_range(7) == 0) begin
      write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
    end
  endtask

  // mostly a loop settling near the target, some full-range and raw bit patterns
  function automatic logic signed [ANGLE_W-1:0] next_angle();
    int roll;
    case ($urandom_range(19))
      0, 1, 2: roll = int'($urandom_range(511)) - 256;
      3, 4, 5, 6, 7: roll = int'($urandom_range(360)) - 180;
      default: roll = aim + int'($urandom_range(40)) - 20;
    endcase
    return ANGLE_W'(roll);
  endfunction

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset gains: angle extremes and sign flips for the derivative
    foreach (opening_angles[k]) send_angle(opening_angles[k]);
    settle();

    // full gains, high bits beyond each register dropped
    write_reg(REG_GAIN_P, '1);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '1);
    write_reg(REG_SET_ANGLE, {7'h7F, 9'd180});
    write_reg(REG_BASE_THRUST, '1);
    aim = 180;
    send_angle(ANGLE_MIN);
    send_angle(ANGLE_MAX);
    send_angle(180);
    settle();

    // zero gains, writes to unused indexes must change nothing
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '0);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_SET_ANGLE, CFG_DATA_W'(-180));
    write_reg(REG_BASE_THRUST, 16'd128);
    write_reg(REG_SPARE_FIRST, '1);
    write_reg(REG_SPARE_LAST, '1);
    aim = -180;
    send_angle(ANGLE_MAX);
    send_angle(ANGLE_MIN);
    send_angle(0);
    settle();

    // half gain: rounding of halves and clamping at the top end
    write_reg(REG_GAIN_P, 16'd2048);
    write_reg(REG_SET_ANGLE, '0);
    aim = 0;
    send_angle(1);
    send_angle(-1);
    send_angle(3);
    send_angle(-3);
    send_angle(ANGLE_MAX);

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          in_idle_pct = 6;
          out_idle_pct <= 58;
        end
        1: begin
          in_idle_pct = 58;
          out_idle_pct <= 6;
        end
        default: begin
          in_idle_pct = 0;
          out_idle_pct <= 0;
        end
      endcase
      for (int setting = 0; setting < SETTINGS_PER_MODE; setting++) begin
        settle();
        load_random_settings();
        for (int n = 0; n < WORDS_PER_SETTING; n++) begin
          if (mode == 0 && setting == 1 && n == 20) hold_request <= 1'b1;
          send_angle(next_angle());
        end
      end
    end

    // integral pushed hard one way, then the other, thrusts pinned at both ends
    settle();
    write_reg(REG_GAIN_P, '0);
    write_reg(REG_GAIN_I, '1);
    write_reg(REG_GAIN_D, '0);
    write_reg(REG_BASE_THRUST, 16'd128);
    write_reg(REG_SET_ANGLE, CFG_DATA_W'(ANGLE_MAX));
    repeat (SAT_RUN) send_angle(ANGLE_MIN);
    settle();
    write_reg(REG_SET_ANGLE, {7'h00, ANGLE_MIN});
    repeat (2 * SAT_RUN) send_angle(ANGLE_MAX);
    settle();
    write_reg(REG_SET_ANGLE, CFG_DATA_W'(ANGLE_MAX));
    repeat (SAT_RUN) send_angle(ANGLE_MIN);

    settle();
    if (fail_count == 0 && words_in_flight == 0) begin
      $display("PASS pid_differential_thrust_top");
    end else begin
      $display("FAIL pid_differential_thrust_top");
    end
    $finish;
  end

endmodule

### pid_differential_thrust_top.f
+incdir+rtl
rtl/pdt_pkg.sv
rtl/pdt_integrator.sv
rtl/pdt_effort.sv
rtl/pdt_mix.sv
rtl/pid_differential_thrust_top.sv
test/pid_differential_thrust_checker.sv
test/pid_differential_thrust_top_test.sv
